>>> rtl/sorted_relative_label_table_defines.svh
// Assertion macros for the label table block.
// Included by modules that carry assertions; no dependencies.
`ifndef SORTED_RELATIVE_LABEL_TABLE_DEFINES_SVH
`define SORTED_RELATIVE_LABEL_TABLE_DEFINES_SVH
`ifndef SYNTH
`define SRLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRLT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRLT_ASSERT(label, clk, rst_n, prop, msg)
`define SRLT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> rtl/srlt_pkg.sv
// Shared types and constants for the sorted label table.
// No dependencies.
`default_nettype none
package srlt_pkg;
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 18;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_FWD = 2'd1;
    localparam logic [1:0] KIND_BWD = 2'd2;
    localparam logic [1:0] KIND_BAD = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [15:0] address;
        logic [1:0]  label_kind;
        logic [7:0]  delta;
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_INS_RD, ST_INS_WR, ST_FWD_RD,
        ST_FWD_CHK, ST_BWD_RD, ST_BWD_CHK, ST_DONE
    } state_t;
endpackage
`default_nettype wire

>>> rtl/srlt_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module srlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     clk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] addr,
    input  wire [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> rtl/srlt_front.sv
// Front end: accepts requests, flags trivial ones for the back end, holds a 2-entry queue.
// Depends on srlt_pkg.
`default_nettype none
module srlt_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  wire srlt_pkg::req_t in_req,
    output logic                q_valid,
    output srlt_pkg::req_t      q_req,
    output logic                q_trivial,
    input  wire                 q_take
);
    import srlt_pkg::*;
    `include "sorted_relative_label_table_defines.svh"

    // trivial: kind three insert or zero-delta lookup, answered without the table
    logic [1:0] vld_reg, vld_next;
    req_t       req_reg [2];
    logic [1:0] triv_reg;
    logic       push, pop, triv_in;

    assign in_stall = vld_reg[1];
    assign push = in_valid && !in_stall;
    assign pop = q_take && vld_reg[0];
    assign triv_in = (in_req.mode == MODE_INSERT) ? (in_req.label_kind == KIND_BAD)
                                                  : (in_req.delta == 8'd0);
    assign q_valid = vld_reg[0];
    assign q_req = req_reg[0];
    assign q_trivial = triv_reg[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (pop)
            vld_next = {1'b0, vld_reg[1]};
        if (push)
        begin
            if (vld_next[0])
                vld_next[1] = 1'b1;
            else
                vld_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // slot 0 takes the new request when it lands at the head, else the shifted slot 1
    always_ff @(posedge clk)
    begin
        if (push && (pop ? !vld_reg[1] : !vld_reg[0]))
        begin
            req_reg[0] <= in_req;
            triv_reg[0] <= triv_in;
        end
        else if (pop)
        begin
            req_reg[0] <= req_reg[1];
            triv_reg[0] <= triv_reg[1];
        end
        if (push && (pop ? vld_reg[1] : vld_reg[0]))
        begin
            req_reg[1] <= in_req;
            triv_reg[1] <= triv_in;
        end
    end

    `SRLT_ASSERT(a_q_order, clk, rst_n, vld_reg[1] |-> vld_reg[0], "queue hole")
    `SRLT_ASSERT(a_full_stall, clk, rst_n, (vld_reg[1] && !pop) |=> vld_reg[1], "lost entry")
    `SRLT_ASSERT(a_no_pop_empty, clk, rst_n, !vld_reg[0] |=> !(vld_reg[1]), "phantom fill")
endmodule
`default_nettype wire

>>> rtl/srlt_back.sv
// Back end: sequencer over the entry RAM for sorted insert and relative walk.
// Depends on srlt_pkg and srlt_ram.
`default_nettype none
module srlt_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    input  wire srlt_pkg::req_t q_req,
    input  wire                 q_trivial,
    output logic                q_take,
    output logic                out_valid,
    input  wire                 out_stall,
    output logic                found,
    output logic [15:0]         result_address,
    output logic                overflow
);
    import srlt_pkg::*;
    `include "sorted_relative_label_table_defines.svh"

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]       n_reg, n_next;
    req_t             req_reg, req_next;
    logic             found_reg, found_next, ovf_reg, ovf_next;
    logic [15:0]      res_reg, res_next;

    logic             we;
    logic [IDX_W-1:0] ram_addr;
    logic [ENT_W-1:0] wdata, rdata;
    logic [15:0]      ent_a;
    logic [1:0]       ent_k;

    srlt_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
    );

    assign ent_a = rdata[17:2];
    assign ent_k = rdata[1:0];
    assign out_valid = (state_reg == ST_DONE);
    assign found = found_reg;
    assign result_address = res_reg;
    assign overflow = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        n_next = n_reg;
        req_next = req_reg;
        found_next = found_reg;
        ovf_next = ovf_reg;
        res_next = res_reg;
        q_take = 1'b0;
        we = 1'b0;
        ram_addr = idx_reg[IDX_W-1:0];
        wdata = rdata;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    req_next = q_req;
                    found_next = 1'b0;
                    ovf_next = 1'b0;
                    res_next = '0;
                    idx_next = '0;
                    n_next = q_req.delta[7] ? (8'd0 - q_req.delta) : q_req.delta;
                    state_next = q_trivial ? ST_DONE : ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                // find first entry not below the address
                if (idx_reg == count_reg)
                begin
                    pos_next = idx_reg;
                    if (req_reg.mode == MODE_INSERT)
                    begin
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            ovf_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                            state_next = ST_INS_WR;
                    end
                    else if (req_reg.delta[7])
                        state_next = ST_BWD_RD;
                    else
                        state_next = ST_DONE;
                end
                else
                    state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (ent_a < req_reg.address)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    pos_next = idx_reg;
                    if (req_reg.mode == MODE_INSERT)
                    begin
                        if (ent_a == req_reg.address)
                            state_next = ST_DONE;
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            ovf_next = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            idx_next = count_reg;
                            state_next = ST_INS_RD;
                        end
                    end
                    else if (req_reg.delta[7])
                        state_next = ST_BWD_RD;
                    else
                        state_next = ST_FWD_CHK;
                end
            end
            ST_INS_RD:
            begin
                // shift entries up one from the top down to pos
                if (idx_reg == pos_reg)
                    state_next = ST_INS_WR;
                else
                begin
                    ram_addr = IDX_W'(idx_reg - 1'b1);
                    state_next = ST_INS_WR;
                end
            end
            ST_INS_WR:
            begin
                if (idx_reg == pos_reg)
                begin
                    we = 1'b1;
                    ram_addr = pos_reg[IDX_W-1:0];
                    wdata = {req_reg.address, req_reg.label_kind};
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    we = 1'b1;
                    idx_next = idx_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
            end
            ST_FWD_RD:
            begin
                if (idx_reg == count_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_FWD_CHK;
            end
            ST_FWD_CHK:
            begin
                idx_next = idx_reg + 1'b1;
                ram_addr = IDX_W'(idx_reg + 1'b1);
                state_next = ST_FWD_RD;
                if (ent_a != req_reg.address && (ent_k == KIND_PLAIN || ent_k == KIND_FWD))
                begin
                    n_next = n_reg - 1'b1;
                    if (n_reg == 8'd1)
                    begin
                        found_next = 1'b1;
                        res_next = ent_a;
                        state_next = ST_DONE;
                    end
                end
                if (state_next == ST_FWD_RD && idx_next == count_reg)
                    state_next = ST_DONE;
            end
            ST_BWD_RD:
            begin
                if (pos_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    ram_addr = IDX_W'(pos_reg - 1'b1);
                    pos_next = pos_reg - 1'b1;
                    state_next = ST_BWD_CHK;
                end
            end
            ST_BWD_CHK:
            begin
                state_next = ST_BWD_RD;
                if (ent_k == KIND_PLAIN || ent_k == KIND_BWD)
                begin
                    n_next = n_reg - 1'b1;
                    if (n_reg == 8'd1)
                    begin
                        found_next = 1'b1;
                        res_next = ent_a;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        n_reg <= n_next;
        req_reg <= req_next;
        found_reg <= found_next;
        ovf_reg <= ovf_next;
        res_reg <= res_next;
    end

    `SRLT_ASSERT(a_cnt_max, clk, rst_n, count_reg <= CNT_W'(TABLE_DEPTH), "count past depth")
    `SRLT_ASSERT(a_excl, clk, rst_n, out_valid |-> !(found && overflow), "found with overflow")
    `SRLT_ASSERT(a_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(res_reg)),
        "result changed under stall")
    `SRLT_ASSERT(a_cnt_step, clk, rst_n, (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + 1'b1), "count jump")
endmodule
`default_nettype wire

>>> rtl/sorted_relative_label_table.sv
// Top level of the sorted anonymous label table.
// Depends on srlt_pkg, srlt_front and srlt_back.
`default_nettype none
// Sorted label table: inserts keep ascending address order; lookups walk away
// from a reference address counting labels of the matching kinds. A request
// alternates RAM reads and checks: locating the place reads and compares each
// entry below the address, an insert then reads and writes each entry shifted
// before the final write, and a lookup reads and checks each entry walked. The
// single-port entry RAM sets this pace. A two-deep request queue lets new
// requests enter while the sequencer works; zero-delta lookups and kind-three
// inserts skip the table. No clearing pass: the entry count alone marks valid
// entries.
module sorted_relative_label_table (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         mode,
    input  wire  [15:0] address,
    input  wire  [1:0]  label_kind,
    input  wire  [7:0]  delta,
    output logic        out_valid,
    input  wire         out_stall,
    output logic        found,
    output logic [15:0] result_address,
    output logic        overflow
);
    import srlt_pkg::*;

    req_t in_req, q_req;
    logic q_valid, q_trivial, q_take;

    assign in_req = '{mode: mode, address: address, label_kind: label_kind, delta: delta};

    srlt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_req(in_req), .q_valid(q_valid), .q_req(q_req), .q_trivial(q_trivial),
        .q_take(q_take)
    );

    srlt_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req),
        .q_trivial(q_trivial), .q_take(q_take), .out_valid(out_valid),
        .out_stall(out_stall), .found(found), .result_address(result_address),
        .overflow(overflow)
    );
endmodule
`default_nettype wire

>>> tb/sv/label_table_checker.sv
// Checker for the sorted label table: watches both channels, predicts answers.
// Depends on srlt_pkg for codes and table depth.
module label_table_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire         mode,
    input  wire  [15:0] address,
    input  wire  [1:0]  label_kind,
    input  wire  [7:0]  delta,
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire         found,
    input  wire  [15:0] result_address,
    input  wire         overflow,
    output int          fail_count,
    output int          pending
);
    import srlt_pkg::*;

    typedef struct packed {
        logic        found;
        logic [15:0] addr;
        logic        ovf;
    } label_answer_t;

    logic [15:0]   tbl_addr [TABLE_DEPTH];
    logic [1:0]    tbl_kind [TABLE_DEPTH];
    int            tbl_count = 0;
    int            fails = 0;
    label_answer_t answer_q[$];

    assign fail_count = fails;
    assign pending = answer_q.size();

    // Applies one request to the shadow table and returns its answer.
    function automatic label_answer_t apply_request(logic m, logic [15:0] a,
                                                    logic [1:0] k, logic [7:0] d);
        label_answer_t r;
        int p;
        int n;
        r = '0;
        p = 0;
        while (p < tbl_count && tbl_addr[p] < a) p++;
        if (m == MODE_INSERT)
        begin
            if (k != KIND_BAD)
            begin
                if (p < tbl_count && tbl_addr[p] == a)
                begin
                    // duplicate: no change
                end
                else if (tbl_count >= TABLE_DEPTH)
                begin
                    r.ovf = 1'b1;
                end
                else
                begin
                    for (int i = tbl_count; i > p; i--)
                    begin
                        tbl_addr[i] = tbl_addr[i-1];
                        tbl_kind[i] = tbl_kind[i-1];
                    end
                    tbl_addr[p] = a;
                    tbl_kind[p] = k;
                    tbl_count++;
                end
            end
        end
        else if (d != 8'd0)
        begin
            if (d < 8'd128)
            begin
                n = d;
                for (int i = p; i < tbl_count; i++)
                begin
                    if (tbl_addr[i] != a && (tbl_kind[i] == KIND_PLAIN ||
                                             tbl_kind[i] == KIND_FWD))
                    begin
                        n--;
                        if (n == 0)
                        begin
                            r.found = 1'b1;
                            r.addr = tbl_addr[i];
                            break;
                        end
                    end
                end
            end
            else
            begin
                n = 256 - int'(d);
                for (int i = p; i > 0; i--)
                begin
                    if (tbl_kind[i-1] == KIND_PLAIN || tbl_kind[i-1] == KIND_BWD)
                    begin
                        n--;
                        if (n == 0)
                        begin
                            r.found = 1'b1;
                            r.addr = tbl_addr[i-1];
                            break;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        label_answer_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("answer with no request outstanding");
                    fails++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d actual %0d", want.found, found);
                        fails++;
                    end
                    if (result_address !== want.addr)
                    begin
                        $error("result_address: expected %h actual %h",
                               want.addr, result_address);
                        fails++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0d actual %0d", want.ovf, overflow);
                        fails++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answer_q = {answer_q, apply_request(mode, address, label_kind, delta)};
        end
    end
endmodule

>>> tb/sv/testbench.sv
// Top of the label table testbench: clock, reset, requests and the verdict.
// Depends on srlt_pkg, sorted_relative_label_table and label_table_checker.
module testbench;
    import srlt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_INSERT;
    logic [15:0] address = '0;
    logic [1:0]  label_kind = KIND_PLAIN;
    logic [7:0]  delta = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        found;
    logic [15:0] result_address;
    logic        overflow;
    int          fail_count;
    int          pending;

    // percent of cycles the sender / receiver hold off
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #4 clk = ~clk;

    sorted_relative_label_table dut (.*);

    label_table_checker chk (.*);

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Offer one request; returns once it has been taken.
    task automatic send_request(logic m, logic [15:0] a, logic [1:0] k, logic [7:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        address    <= a;
        label_kind <= k;
        delta      <= d;
        do @(posedge clk); while (in_stall);
    endtask

    // Mostly addresses from a narrow pool so inserts collide and lookups hit.
    task automatic random_request();
        logic [15:0] a;
        logic [7:0]  d;
        logic [1:0]  k;
        a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(2000, 2063));
        k = ($urandom_range(15) == 0) ? KIND_BAD : 2'($urandom_range(2));
        if ($urandom_range(4) == 0) d = 8'($urandom);
        else d = 8'($signed($urandom_range(16)) - 8);
        send_request($urandom_range(1) ? MODE_LOOKUP : MODE_INSERT, a, k, d);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, kinds, duplicates, skipped kind
        send_request(MODE_LOOKUP, 16'h0100, KIND_PLAIN, 8'h01);
        send_request(MODE_LOOKUP, 16'h0100, KIND_PLAIN, 8'hFF);
        send_request(MODE_INSERT, 16'h0000, KIND_PLAIN, 8'h00);
        send_request(MODE_INSERT, 16'hFFFF, KIND_BWD, 8'hFF);
        send_request(MODE_INSERT, 16'h0100, KIND_FWD, 8'h00);
        send_request(MODE_INSERT, 16'h0200, KIND_BWD, 8'h00);
        send_request(MODE_INSERT, 16'h0300, KIND_PLAIN, 8'h00);
        send_request(MODE_INSERT, 16'h0100, KIND_BWD, 8'h00);   // duplicate, other kind
        send_request(MODE_INSERT, 16'h0400, KIND_BAD, 8'h00);   // ignored kind
        send_request(MODE_LOOKUP, 16'h0400, KIND_BAD, 8'h01);
        send_request(MODE_LOOKUP, 16'h0200, KIND_PLAIN, 8'h01); // self not counted
        send_request(MODE_LOOKUP, 16'h0200, KIND_PLAIN, 8'hFF);
        send_request(MODE_LOOKUP, 16'h0100, KIND_PLAIN, 8'h02);
        send_request(MODE_LOOKUP, 16'h0300, KIND_PLAIN, 8'hFE);
        send_request(MODE_LOOKUP, 16'h0300, KIND_PLAIN, 8'h00);  // zero delta
        send_request(MODE_LOOKUP, 16'h0000, KIND_PLAIN, 8'h7F);
        send_request(MODE_LOOKUP, 16'hFFFF, KIND_PLAIN, 8'h80);
        send_request(MODE_LOOKUP, 16'h0000, KIND_PLAIN, 8'h03);
        send_request(MODE_LOOKUP, 16'hFFFF, KIND_PLAIN, 8'hFD);
        send_request(MODE_LOOKUP, 16'h8000, KIND_PLAIN, 8'hFF);
        drain();

        send_idle_pct = 34; recv_stall_pct = 53;
        repeat (100) random_request();
        drain();    // sender waits for every answer

        send_idle_pct = 53; recv_stall_pct = 34;
        repeat (100) random_request();

        // fill the table past full; 251 is odd so these addresses are distinct
        send_idle_pct = 0; recv_stall_pct = 0;
        for (int i = 0; i < 280; i++)
            send_request(MODE_INSERT, 16'(i * 251), 2'($urandom_range(2)), 8'($urandom));
        repeat (20) send_request(MODE_LOOKUP, 16'($urandom), KIND_PLAIN, 8'($urandom));

        drain();
        repeat (600) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
